@@ sv/prtq_pkg.sv @@
// ----------------------------------------------------------------------------
// prtq_pkg
// Shared types and constants for the posted-receive tag match queue: queue
// sizing, operation codes, the stored entry and the per-cell control group.
// ----------------------------------------------------------------------------
package prtq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_APPEND      = 2'd0;
  localparam logic [1:0] OP_FIND        = 2'd1;
  localparam logic [1:0] OP_FIND_REMOVE = 2'd2;
  localparam logic [1:0] OP_CANCEL      = 2'd3;

  localparam logic CFG_ANY_TAG    = 1'b0;
  localparam logic CFG_ANY_SOURCE = 1'b1;

  typedef struct packed {
    logic [31:0]            tag;
    logic [63:0]            source;
    logic [HANDLE_BITS-1:0] handle;
    logic                   wild_tag;
    logic                   wild_src;
  } prtq_entry_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [31:0]            tag;
    logic [63:0]            source;
    logic [HANDLE_BITS-1:0] handle;
  } prtq_query_t;

  typedef struct packed {
    logic capture;  // register the hit flag for the query on the inputs
    logic load;     // take the appended entry
    logic shift;    // take the younger neighbour's entry
  } prtq_cell_ctrl_t;

endpackage

@@ sv/prtq_cell.sv @@
// ----------------------------------------------------------------------------
// prtq_cell
// One queue slot: holds an entry, compares it against the incoming query and
// moves its younger neighbour's entry in when it or an older one is removed.
// ----------------------------------------------------------------------------
module prtq_cell import prtq_pkg::*; (
  input  logic            clk,
  input  prtq_cell_ctrl_t ctrl,
  input  prtq_query_t     query,
  input  prtq_entry_t     load_entry,
  input  prtq_entry_t     next_entry,
  output prtq_entry_t     entry,
  output logic            hit
);

  prtq_entry_t entry_r, entry_nxt;
  logic        hit_r, hit_nxt;
  logic        tag_ok, src_ok;

  always_comb begin
    // A wildcard tag entry also matches any non-negative incoming tag.
    tag_ok = (entry_r.tag == query.tag) || (entry_r.wild_tag && !query.tag[31]);
    src_ok = entry_r.wild_src || (entry_r.source == query.source);
    if (query.op == OP_CANCEL) begin
      hit_nxt = (entry_r.handle == query.handle);
    end else begin
      hit_nxt = tag_ok && src_ok;
    end
  end

  always_comb begin
    if (ctrl.load) begin
      entry_nxt = load_entry;
    end else if (ctrl.shift) begin
      entry_nxt = next_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.capture) begin
      hit_r <= hit_nxt;
    end
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

@@ sv/posted_receive_tag_match_queue_top.sv @@
// ----------------------------------------------------------------------------
// posted_receive_tag_match_queue_top
// Ordered posted-receive queue built as a row of cells, oldest entry in cell
// zero. Append, find, find-and-remove and cancel-by-handle.
//
//   Port group   Handshake              Payload
//   in_*         in_valid / in_ready    op, tag, source, handle
//   out_*        out_valid / out_ready  found, match_handle, status, occupancy
//   cfg_*        cfg_we                 cfg_index, cfg_wdata
//
// Every cell compares its entry with the query on the accepting edge and
// registers its hit. The resolve state then picks the oldest hit, shifts
// the cells from it upwards down one place on a removal, loads an appended
// entry into the first free cell and loads the result register. No request
// is taken before the last is resolved; resolve holds while a result waits.
// Synchronous reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
module posted_receive_tag_match_queue_top import prtq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_tag,
  input  logic [63:0]        in_source,
  input  logic [15:0]        in_handle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [15:0]        out_match_handle,
  output logic               out_status,
  output logic [6:0]         out_occupancy,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [31:0]            any_tag_r, any_source_r;
  prtq_query_t            query_in, query_r;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [15:0]            out_match_handle_r;
  logic                   out_status_r;
  logic [6:0]             out_occupancy_r;

  prtq_entry_t            ent [QUEUE_DEPTH];
  prtq_cell_ctrl_t        ctrl [QUEUE_DEPTH];
  prtq_entry_t            load_entry;
  logic [QUEUE_DEPTH-1:0] hit_vec, valid_mask, hits, first_hit, at_or_after;
  logic [HANDLE_BITS-1:0] sel_handle;
  logic                   any_hit, is_append, full, append_ok, remove, found;
  logic                   accept, do_resolve;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign query_in.op     = in_op;
  assign query_in.tag    = in_tag;
  assign query_in.source = in_source;
  assign query_in.handle = HANDLE_BITS'(in_handle);

  assign load_entry.tag      = query_r.tag;
  assign load_entry.source   = query_r.source;
  assign load_entry.handle   = query_r.handle;
  assign load_entry.wild_tag = (query_r.tag == any_tag_r);
  assign load_entry.wild_src = (query_r.source[31:0] == any_source_r);

  // Oldest hit among the held entries, and every cell from it upwards.
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      valid_mask[k] = (CNT_W'(k) < count_r);
    end
    hits        = hit_vec & valid_mask;
    any_hit     = |hits;
    first_hit   = hits & (~hits + QUEUE_DEPTH'(1));
    at_or_after = ~(first_hit - QUEUE_DEPTH'(1));
    sel_handle  = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      sel_handle = sel_handle | (ent[k].handle & {HANDLE_BITS{first_hit[k]}});
    end
  end

  always_comb begin
    is_append  = (query_r.op == OP_APPEND);
    full       = (count_r == CNT_W'(QUEUE_DEPTH));
    append_ok  = is_append && !full;
    found      = !is_append && any_hit;
    remove     = found && ((query_r.op == OP_FIND_REMOVE) || (query_r.op == OP_CANCEL));
    do_resolve = (state_r == ST_RESOLVE) && (!out_valid_r || out_ready);
    if (append_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (remove) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (do_resolve) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    assign ctrl[g].capture = accept;
    assign ctrl[g].load    = do_resolve && append_ok && (count_r == CNT_W'(g));
    assign ctrl[g].shift   = do_resolve && remove && at_or_after[g];

    prtq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .query      (query_in),
      .load_entry (load_entry),
      .next_entry (ent[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
      .entry      (ent[g]),
      .hit        (hit_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      any_tag_r    <= '1;
      any_source_r <= '1;
    end else begin
      state_r <= state_nxt;
      if (do_resolve) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ANY_TAG:    any_tag_r    <= cfg_wdata;
          CFG_ANY_SOURCE: any_source_r <= cfg_wdata;
          default:        any_tag_r    <= any_tag_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query_r <= query_in;
    end
    if (do_resolve) begin
      out_found_r        <= found;
      out_match_handle_r <= found ? 16'(sel_handle) : 16'd0;
      out_status_r       <= is_append && full;
      out_occupancy_r    <= 7'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_handle = out_match_handle_r;
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occupancy_r;

endmodule

@@ sv/prtq_checker.sv @@
// ----------------------------------------------------------------------------
// prtq_checker
// Port-level checks on the result channel of the posted-receive queue,
// attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module prtq_checker import prtq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [15:0] out_match_handle,
  input logic        out_status,
  input logic [6:0]  out_occupancy
);

  // The queue never reports more entries than it can hold.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= 7'(QUEUE_DEPTH)))
    else $error("occupancy beyond queue depth");

  // A refused append only happens on a full queue and never reports a match.
  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> ((out_occupancy == 7'(QUEUE_DEPTH)) && !out_found))
    else $error("refused append without a full queue");

  // Without a match the reported handle is zero.
  a_no_match_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_handle == 16'd0))
    else $error("handle reported without a match");

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_occupancy)
                                   && $stable(out_found) && $stable(out_match_handle)))
    else $error("stalled result changed");

endmodule

bind posted_receive_tag_match_queue_top prtq_checker u_prtq_checker (.*);

@@ test/posted_receive_tag_match_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// posted_receive_tag_match_queue_top_tb
// Self-checking bench for the posted-receive tag match queue. A short table
// of directed requests covers the empty queue, wildcard entries, field
// extremes and each operation. Random traffic follows under several wildcard
// code settings, with fill and drain phases that reach the full queue.
// Each result is compared with a typed table result or a behavioural model.
// ----------------------------------------------------------------------------
module posted_receive_tag_match_queue_top_tb;
  import prtq_pkg::*;

  typedef struct packed {
    logic        found;
    logic [15:0] match_handle;
    logic        status;
    logic [6:0]  occupancy;
  } match_result_t;

  typedef struct packed {
    prtq_query_t   query;
    logic          typed;
    match_result_t want;
  } stim_row_t;

  typedef enum int {MIX_TRAFFIC, FILL_QUEUE, DRAIN_QUEUE} traffic_mode_t;

  localparam int            STALL_LIMIT = 2000;
  localparam match_result_t NO_HIT      = '0;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic signed [31:0] in_tag;
  logic [63:0]        in_source;
  logic [15:0]        in_handle;
  logic               out_valid;
  logic               out_ready;
  logic               out_found;
  logic [15:0]        out_match_handle;
  logic               out_status;
  logic [6:0]         out_occupancy;
  logic               cfg_we;
  logic               cfg_index;
  logic [31:0]        cfg_wdata;

  // Model state: posted entries oldest first, and the wildcard codes.
  prtq_entry_t   posted_q[$];
  logic [31:0]   wild_tag_value = '1;
  logic [31:0]   wild_src_value = '1;
  match_result_t expected_q[$];

  int   errors = 0;
  int   idle_cycles = 0;
  logic gaps_on;
  int   burst_left;

  // The queue starts empty with the codes at their reset value of all ones.
  stim_row_t dir_rows [19] = '{
    '{'{OP_FIND,        32'h0000_0000, 64'h0, 16'h0000}, 1'b1, NO_HIT},
    '{'{OP_CANCEL,      32'h0000_0000, 64'h0, 16'hFFFF}, 1'b1, NO_HIT},
    '{'{OP_FIND_REMOVE, 32'hFFFF_FFFF, '1,    16'h0000}, 1'b1, NO_HIT},
    '{'{OP_APPEND,      32'hFFFF_FFFF, 64'h0, 16'h0001}, 1'b1,
      '{1'b0, 16'h0, 1'b0, 7'd1}},
    '{'{OP_APPEND,      32'h8000_0000, '1,    16'hFFFF}, 1'b1,
      '{1'b0, 16'h0, 1'b0, 7'd2}},
    '{'{OP_APPEND,      32'h7FFF_FFFF, 64'h8000_0000_0000_0000, 16'h0000}, 1'b1,
      '{1'b0, 16'h0, 1'b0, 7'd3}},
    '{'{OP_APPEND,      32'h0000_0005, 64'hFFFF_FFFF_0000_0000, 16'h0001}, 1'b1,
      '{1'b0, 16'h0, 1'b0, 7'd4}},
    '{'{OP_FIND,        32'hFFFF_FFFB, 64'h0, 16'h0000}, 1'b0, NO_HIT},
    '{'{OP_FIND,        32'hFFFF_FFFF, 64'h0, 16'h0000}, 1'b0, NO_HIT},
    '{'{OP_FIND,        32'h0000_0000, 64'h0, 16'h0000}, 1'b0, NO_HIT},
    '{'{OP_FIND,        32'h8000_0000, 64'h123, 16'h0000}, 1'b0, NO_HIT},
    '{'{OP_FIND,        32'h7FFF_FFFF, 64'h8000_0000_0000_0000, 16'h0}, 1'b0, NO_HIT},
    '{'{OP_FIND_REMOVE, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000, 16'h0}, 1'b0, NO_HIT},
    '{'{OP_CANCEL,      32'h0000_0000, 64'h0, 16'h0001}, 1'b0, NO_HIT},
    '{'{OP_FIND,        32'h0000_0009, 64'h0, 16'h0000}, 1'b0, NO_HIT},
    '{'{OP_CANCEL,      32'h0000_0000, 64'h0, 16'h1234}, 1'b0, NO_HIT},
    '{'{OP_FIND_REMOVE, 32'h0000_0005, 64'hFFFF_FFFF_0000_0000, 16'h0}, 1'b0, NO_HIT},
    '{'{OP_CANCEL,      32'h0000_0000, 64'h0, 16'hFFFF}, 1'b0, NO_HIT},
    '{'{OP_FIND_REMOVE, 32'h0000_0000, 64'h0, 16'h0000}, 1'b1, NO_HIT}
  };

  posted_receive_tag_match_queue_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_tag           (in_tag),
    .in_source        (in_source),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_handle (out_match_handle),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic entry_hits(prtq_entry_t e, logic [31:0] tag, logic [63:0] src);
    return ((e.tag == tag) || (e.wild_tag && !tag[31])) && (e.wild_src || e.source == src);
  endfunction

  // Applies one request to the model queue and returns the result it gives.
  function automatic match_result_t apply_request(prtq_query_t q);
    match_result_t r;
    prtq_entry_t   e;
    int            hit;
    r   = NO_HIT;
    hit = -1;
    case (q.op)
      OP_APPEND: begin
        if (posted_q.size() >= QUEUE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          e.tag      = q.tag;
          e.source   = q.source;
          e.handle   = q.handle;
          e.wild_tag = (q.tag == wild_tag_value);
          e.wild_src = (q.source[31:0] == wild_src_value);
          posted_q.push_back(e);
        end
      end
      OP_FIND, OP_FIND_REMOVE: begin
        foreach (posted_q[k])
          if (hit < 0 && entry_hits(posted_q[k], q.tag, q.source)) hit = k;
      end
      default: begin
        foreach (posted_q[k])
          if (hit < 0 && posted_q[k].handle == q.handle) hit = k;
      end
    endcase
    if (hit >= 0) begin
      r.found        = 1'b1;
      r.match_handle = posted_q[hit].handle;
      if (q.op != OP_FIND) posted_q.delete(hit);
    end
    r.occupancy = 7'(posted_q.size());
    return r;
  endfunction

  function automatic prtq_query_t random_request(logic [1:0] op);
    prtq_query_t q;
    prtq_entry_t e;
    q.op = op;
    case ($urandom_range(0, 9))
      0:       q.tag = wild_tag_value;
      1:       q.tag = $urandom;
      2:       q.tag = 32'h8000_0000;
      3:       q.tag = 32'h7FFF_FFFF;
      4:       q.tag = 32'hFFFF_FFFF - $urandom_range(0, 2);
      default: q.tag = $urandom_range(0, 5);
    endcase
    case ($urandom_range(0, 7))
      0:       q.source = {$urandom, wild_src_value};
      1:       q.source = {$urandom, $urandom};
      2:       q.source = '1;
      3:       q.source = 64'h8000_0000_0000_0000;
      default: q.source = 64'($urandom_range(0, 3));
    endcase
    q.handle = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    // Most lookups are aimed at an entry that is held, so that hits are common.
    if (op != OP_APPEND && posted_q.size() != 0 && $urandom_range(0, 2) != 0) begin
      e        = posted_q[$urandom_range(0, posted_q.size() - 1)];
      q.tag    = e.tag;
      q.source = e.source;
      q.handle = e.handle;
      if (e.wild_tag && $urandom_range(0, 1)) q.tag = $urandom & 32'h7FFF_FFFF;
      if (e.wild_src && $urandom_range(0, 1)) q.source = {$urandom, $urandom};
    end
    return q;
  endfunction

  // Drives one request and records what it should give once it is accepted.
  task automatic send_request(input prtq_query_t q, input logic typed,
                              input match_result_t want);
    match_result_t r;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_op     <= q.op;
    in_tag    <= q.tag;
    in_source <= q.source;
    in_handle <= q.handle;
    do @(posedge clk); while (!in_ready);
    r = apply_request(q);
    expected_q.push_back(typed ? want : r);
  endtask

  task automatic run_traffic(input traffic_mode_t mode, input int count);
    logic [1:0] op;
    int         pick;
    if (mode == FILL_QUEUE)
      while (posted_q.size() < QUEUE_DEPTH) send_request(random_request(OP_APPEND), 1'b0, NO_HIT);
    repeat (count) begin
      pick = $urandom_range(0, 9);
      case (mode)
        FILL_QUEUE:  op = OP_APPEND;
        DRAIN_QUEUE: op = (pick == 0) ? OP_APPEND : (pick < 4) ? OP_FIND_REMOVE :
                          (pick < 7) ? OP_CANCEL : OP_FIND;
        default:     op = (pick < 4) ? OP_APPEND : (pick < 6) ? OP_FIND :
                          (pick < 8) ? OP_FIND_REMOVE : OP_CANCEL;
      endcase
      send_request(random_request(op), 1'b0, NO_HIT);
    end
  endtask

  // Waits until every result is back so that the registers may be written.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_wildcards(input logic [31:0] tag_code, input logic [31:0] src_code);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ANY_TAG;
    cfg_wdata <= tag_code;
    @(negedge clk);
    cfg_index <= CFG_ANY_SOURCE;
    cfg_wdata <= src_code;
    @(negedge clk);
    cfg_we <= 1'b0;
    wild_tag_value = tag_code;
    wild_src_value = src_code;
  endtask

  // The receiver switches between always ready, coin-toss and mostly stalled.
  initial begin
    int span;
    int pattern;
    out_ready = 1'b0;
    forever begin
      span    = $urandom_range(20, 150);
      pattern = $urandom_range(0, 2);
      repeat (span) begin
        @(negedge clk);
        case (pattern)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no request waiting: found %0d, handle %0h",
               out_found, out_match_handle);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          errors++;
        end
        if (out_match_handle !== want.match_handle) begin
          $error("match_handle: expected %0h, got %0h", want.match_handle, out_match_handle);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_occupancy);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("posted_receive_tag_match_queue_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_APPEND;
    in_tag     = '0;
    in_source  = '0;
    in_handle  = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_ANY_TAG;
    cfg_wdata  = '0;
    gaps_on    = 1'b0;
    burst_left = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].query, dir_rows[i].typed, dir_rows[i].want);

    gaps_on = 1'b1;
    run_traffic(MIX_TRAFFIC, 200);
    settle();

    // Entries posted earlier keep the wildcard marks they were given.
    set_wildcards(32'h8000_0000, 32'h7FFF_FFFF);
    run_traffic(FILL_QUEUE, 4);
    gaps_on = 1'b0;
    run_traffic(MIX_TRAFFIC, 80);
    gaps_on = 1'b1;
    run_traffic(DRAIN_QUEUE, 120);
    settle();

    set_wildcards('0, '0);
    run_traffic(MIX_TRAFFIC, 120);
    settle();

    set_wildcards(32'h7FFF_FFFF, 32'h8000_0000);
    run_traffic(FILL_QUEUE, 2);
    run_traffic(DRAIN_QUEUE, 80);
    settle();

    set_wildcards($urandom, $urandom);
    run_traffic(MIX_TRAFFIC, 120);
    settle();

    if (errors == 0) begin
      $display("posted_receive_tag_match_queue_top: match");
    end else begin
      $display("posted_receive_tag_match_queue_top: mismatch");
    end
    $finish;
  end

endmodule

@@ posted_receive_tag_match_queue_top.f @@
sv/prtq_pkg.sv
sv/prtq_cell.sv
sv/posted_receive_tag_match_queue_top.sv
sv/prtq_checker.sv
test/posted_receive_tag_match_queue_top_tb.sv
